/* rtl/core/crcfr_pkg.sv */
// Package for the CRC-32 frame receiver core.
// Holds the item, job and configuration types, the code constants and the bytewise CRC-32 update.
// No dependencies.
`default_nettype none
package crcfr_pkg;

	typedef struct packed {
		logic       item_kind;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [7:0]  data_byte;
		logic [2:0]  frame_status;
		logic [7:0]  frame_command;
		logic [15:0] frame_length;
		logic        last_of_run;
	} out_item_t;

	typedef struct packed {
		logic [7:0]  start_marker;
		logic [7:0]  nack_code;
		logic [7:0]  timeout_code;
		logic [15:0] timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data;
		logic [2:0]  status;
		logic [7:0]  cmd;
		logic [15:0] len;
		logic [7:0]  code;
	} job_t;

	localparam logic [1:0] CFG_START_MARKER  = 2'd0;
	localparam logic [1:0] CFG_NACK_CODE     = 2'd1;
	localparam logic [1:0] CFG_TIMEOUT_CODE  = 2'd2;
	localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd3;

	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	localparam logic [1:0] JOB_PAYLOAD = 2'd0;
	localparam logic [1:0] JOB_STATUS  = 2'd1;
	localparam logic [1:0] JOB_REPLY   = 2'd2;

	localparam logic [1:0] RK_PAYLOAD = 2'd0;
	localparam logic [1:0] RK_REPLY   = 2'd1;
	localparam logic [1:0] RK_STATUS  = 2'd2;

	localparam logic [2:0] ST_GOOD         = 3'd0;
	localparam logic [2:0] ST_BAD_START    = 3'd1;
	localparam logic [2:0] ST_TOO_LONG     = 3'd2;
	localparam logic [2:0] ST_CRC_MISMATCH = 3'd3;
	localparam logic [2:0] ST_MID_TIMEOUT  = 3'd4;
	localparam logic [2:0] ST_IDLE_TIMEOUT = 3'd5;

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

	localparam int QUEUE_DEPTH = 4;

	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'h0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage
`default_nettype wire

/* rtl/core/crcfr_front.sv */
// Front end of the CRC-32 frame receiver: frame parser, CRC check and timeout counter.
// Turns each accepted item into at most one job for the back end. Depends on crcfr_pkg.
`default_nettype none
module crcfr_front #(
	parameter int unsigned MAX_PAYLOAD = 256
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 item_valid,
	input  crcfr_pkg::in_item_t item,
	input  wire                 queue_full,
	input  crcfr_pkg::cfg_t     cfg,
	output logic                job_valid,
	output crcfr_pkg::job_t     job
);

	localparam logic [1:0] PH_WAIT    = 2'd0;
	localparam logic [1:0] PH_HEADER  = 2'd1;
	localparam logic [1:0] PH_PAYLOAD = 2'd2;
	localparam logic [1:0] PH_CRC     = 2'd3;

	logic [1:0]  phase_q, phase_d;
	logic [1:0]  hdr_cnt_q, hdr_cnt_d;
	logic [7:0]  cmd_q, cmd_d;
	logic [15:0] len_q, len_d;
	logic [15:0] pay_cnt_q, pay_cnt_d;
	logic [31:0] crc_q, crc_d;
	logic [23:0] rx_crc_q, rx_crc_d;
	logic [1:0]  crc_cnt_q, crc_cnt_d;
	logic [15:0] idle_q, idle_d;

	logic        accept;
	logic [7:0]  b;
	logic [31:0] crc_upd;
	logic [15:0] idle_inc;
	logic [15:0] tmo_lim;
	logic [15:0] len_full;
	logic [15:0] pay_inc;

	assign accept   = item_valid & ~queue_full;
	assign b        = item.rx_byte;
	assign crc_upd  = crcfr_pkg::crc_byte(crc_q, b);
	assign idle_inc = (idle_q != 16'hFFFF) ? idle_q + 16'd1 : idle_q;
	assign tmo_lim  = (cfg.timeout_ticks == 16'd0) ? 16'd1 : cfg.timeout_ticks;
	assign len_full = {len_q[15:8], b};
	assign pay_inc  = pay_cnt_q + 16'd1;

	always_comb begin
		phase_d   = phase_q;
		hdr_cnt_d = hdr_cnt_q;
		cmd_d     = cmd_q;
		len_d     = len_q;
		pay_cnt_d = pay_cnt_q;
		crc_d     = crc_q;
		rx_crc_d  = rx_crc_q;
		crc_cnt_d = crc_cnt_q;
		idle_d    = idle_q;
		job_valid = 1'b0;
		job       = '0;
		if (accept) begin
			if (item.item_kind == crcfr_pkg::KIND_TICK) begin
				idle_d = idle_inc;
				if (idle_inc >= tmo_lim) begin
					idle_d    = 16'd0;
					job_valid = 1'b1;
					if (phase_q == PH_WAIT) begin
						job.kind   = crcfr_pkg::JOB_STATUS;
						job.status = crcfr_pkg::ST_IDLE_TIMEOUT;
					end else begin
						job.kind   = crcfr_pkg::JOB_REPLY;
						job.status = crcfr_pkg::ST_MID_TIMEOUT;
						job.cmd    = cmd_q;
						job.len    = len_q;
						job.code   = cfg.timeout_code;
					end
					phase_d   = PH_WAIT;
					hdr_cnt_d = 2'd0;
					cmd_d     = 8'd0;
					len_d     = 16'd0;
					pay_cnt_d = 16'd0;
					crc_d     = crcfr_pkg::CRC_INIT;
					rx_crc_d  = 24'd0;
					crc_cnt_d = 2'd0;
				end
			end else begin
				idle_d = 16'd0;
				unique case (phase_q)
					PH_WAIT: begin
						if (b == cfg.start_marker) begin
							phase_d   = PH_HEADER;
							hdr_cnt_d = 2'd0;
							cmd_d     = 8'd0;
							len_d     = 16'd0;
							pay_cnt_d = 16'd0;
							crc_d     = crcfr_pkg::CRC_INIT;
							rx_crc_d  = 24'd0;
							crc_cnt_d = 2'd0;
						end else begin
							job_valid  = 1'b1;
							job.kind   = crcfr_pkg::JOB_STATUS;
							job.status = crcfr_pkg::ST_BAD_START;
						end
					end
					PH_HEADER: begin
						crc_d = crc_upd;
						if (hdr_cnt_q == 2'd0) begin
							cmd_d     = b;
							hdr_cnt_d = 2'd1;
						end else if (hdr_cnt_q == 2'd1) begin
							len_d     = {b, 8'h00};
							hdr_cnt_d = 2'd2;
						end else begin
							len_d     = len_full;
							hdr_cnt_d = 2'd0;
							if (len_full > 16'(MAX_PAYLOAD)) begin
								job_valid  = 1'b1;
								job.kind   = crcfr_pkg::JOB_REPLY;
								job.status = crcfr_pkg::ST_TOO_LONG;
								job.cmd    = cmd_q;
								job.len    = len_full;
								job.code   = cfg.nack_code;
								phase_d    = PH_WAIT;
								cmd_d      = 8'd0;
								len_d      = 16'd0;
								pay_cnt_d  = 16'd0;
								crc_d      = crcfr_pkg::CRC_INIT;
								rx_crc_d   = 24'd0;
								crc_cnt_d  = 2'd0;
							end else if (len_full == 16'd0) begin
								phase_d = PH_CRC;
							end else begin
								pay_cnt_d = 16'd0;
								phase_d   = PH_PAYLOAD;
							end
						end
					end
					PH_PAYLOAD: begin
						crc_d     = crc_upd;
						job_valid = 1'b1;
						job.kind  = crcfr_pkg::JOB_PAYLOAD;
						job.data  = b;
						pay_cnt_d = pay_inc;
						if (pay_inc >= len_q) begin
							phase_d = PH_CRC;
						end
					end
					PH_CRC: begin
						if (crc_cnt_q != 2'd3) begin
							case (crc_cnt_q)
								2'd0:    rx_crc_d[7:0]   = b;
								2'd1:    rx_crc_d[15:8]  = b;
								default: rx_crc_d[23:16] = b;
							endcase
							crc_cnt_d = crc_cnt_q + 2'd1;
						end else begin
							job_valid = 1'b1;
							job.cmd   = cmd_q;
							job.len   = len_q;
							if ({b, rx_crc_q} == ~crc_q) begin
								job.kind   = crcfr_pkg::JOB_STATUS;
								job.status = crcfr_pkg::ST_GOOD;
							end else begin
								job.kind   = crcfr_pkg::JOB_REPLY;
								job.status = crcfr_pkg::ST_CRC_MISMATCH;
								job.code   = cfg.nack_code;
							end
							phase_d   = PH_WAIT;
							hdr_cnt_d = 2'd0;
							cmd_d     = 8'd0;
							len_d     = 16'd0;
							pay_cnt_d = 16'd0;
							crc_d     = crcfr_pkg::CRC_INIT;
							rx_crc_d  = 24'd0;
							crc_cnt_d = 2'd0;
						end
					end
					default: phase_d = PH_WAIT;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_WAIT;
			hdr_cnt_q <= 2'd0;
			cmd_q     <= 8'd0;
			len_q     <= 16'd0;
			pay_cnt_q <= 16'd0;
			crc_q     <= crcfr_pkg::CRC_INIT;
			rx_crc_q  <= 24'd0;
			crc_cnt_q <= 2'd0;
			idle_q    <= 16'd0;
		end else begin
			phase_q   <= phase_d;
			hdr_cnt_q <= hdr_cnt_d;
			cmd_q     <= cmd_d;
			len_q     <= len_d;
			pay_cnt_q <= pay_cnt_d;
			crc_q     <= crc_d;
			rx_crc_q  <= rx_crc_d;
			crc_cnt_q <= crc_cnt_d;
			idle_q    <= idle_d;
		end
	end

endmodule
`default_nettype wire

/* rtl/core/crcfr_queue.sv */
// Job queue between the front end and the back end of the CRC-32 frame receiver.
// A small first-in first-out buffer of jobs. Depends on crcfr_pkg.
`default_nettype none
module crcfr_queue (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             push,
	input  crcfr_pkg::job_t push_job,
	input  wire             pop,
	output logic            head_valid,
	output crcfr_pkg::job_t head_job,
	output logic            full
);

	localparam int Depth = crcfr_pkg::QUEUE_DEPTH;
	localparam int PtrW  = $clog2(Depth);
	localparam int CntW  = $clog2(Depth + 1);

	crcfr_pkg::job_t entry_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign head_valid = (count_q != '0);
	assign full       = (count_q == CntW'(Depth));
	assign head_job   = entry_q[rd_ptr_q];
	assign do_push    = push & ~full;
	assign do_pop     = pop & head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CntW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/core/crcfr_back.sv */
// Back end of the CRC-32 frame receiver: expands jobs into result items.
// Sends reply frames byte by byte with their CRC, then the status, through an output register.
// Depends on crcfr_pkg.
`default_nettype none
module crcfr_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  job_valid,
	input  crcfr_pkg::job_t      job,
	output logic                 job_pop,
	input  crcfr_pkg::cfg_t      cfg,
	output logic                 res_valid,
	output crcfr_pkg::out_item_t res_item,
	input  wire                  res_stall
);

	logic                 busy_q;
	crcfr_pkg::job_t      job_q;
	logic [3:0]           idx_q;
	logic [31:0]          crc_q;
	logic [31:0]          crc_d;
	logic [31:0]          crc_inv;
	logic                 res_valid_q;
	crcfr_pkg::out_item_t res_q;
	crcfr_pkg::out_item_t res_d;
	logic                 advance;

	assign advance   = ~res_valid_q | ~res_stall;
	assign job_pop   = advance & ~busy_q & job_valid;
	assign crc_inv   = ~crc_q;
	assign res_valid = res_valid_q;
	assign res_item  = res_q;

	always_comb begin
		res_d = '0;
		crc_d = crc_q;
		if (busy_q) begin
			res_d.result_kind = crcfr_pkg::RK_REPLY;
			unique case (idx_q)
				4'd1: begin
					res_d.data_byte = job_q.code;
					crc_d = crcfr_pkg::crc_byte(crc_q, job_q.code);
				end
				4'd2, 4'd3: begin
					res_d.data_byte = 8'h00;
					crc_d = crcfr_pkg::crc_byte(crc_q, 8'h00);
				end
				4'd4: res_d.data_byte = crc_inv[7:0];
				4'd5: res_d.data_byte = crc_inv[15:8];
				4'd6: res_d.data_byte = crc_inv[23:16];
				4'd7: res_d.data_byte = crc_inv[31:24];
				default: begin
					res_d.result_kind   = crcfr_pkg::RK_STATUS;
					res_d.frame_status  = job_q.status;
					res_d.frame_command = job_q.cmd;
					res_d.frame_length  = job_q.len;
					res_d.last_of_run   = 1'b1;
				end
			endcase
		end else if (job_valid) begin
			unique case (job.kind)
				crcfr_pkg::JOB_PAYLOAD: begin
					res_d.result_kind = crcfr_pkg::RK_PAYLOAD;
					res_d.data_byte   = job.data;
					res_d.last_of_run = 1'b1;
				end
				crcfr_pkg::JOB_REPLY: begin
					res_d.result_kind = crcfr_pkg::RK_REPLY;
					res_d.data_byte   = cfg.start_marker;
					crc_d             = crcfr_pkg::CRC_INIT;
				end
				default: begin
					res_d.result_kind   = crcfr_pkg::RK_STATUS;
					res_d.frame_status  = job.status;
					res_d.frame_command = job.cmd;
					res_d.frame_length  = job.len;
					res_d.last_of_run   = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
			crc_q <= crc_d;
		end
		if (job_pop) begin
			job_q <= job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= 4'd0;
			res_valid_q <= 1'b0;
		end else if (advance) begin
			if (busy_q) begin
				res_valid_q <= 1'b1;
				if (idx_q == 4'd8) begin
					busy_q <= 1'b0;
					idx_q  <= 4'd0;
				end else begin
					idx_q <= idx_q + 4'd1;
				end
			end else if (job_valid) begin
				res_valid_q <= 1'b1;
				if (job.kind == crcfr_pkg::JOB_REPLY) begin
					busy_q <= 1'b1;
					idx_q  <= 4'd1;
				end
			end else begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/core/crc32_frame_receiver_core.sv */
// Top level of the CRC-32 frame receiver: configuration registers, front end, job queue, back end.
// Takes one byte or tick item per cycle while the four-entry job queue has room.
// The first result of an item passes through the job queue and then the back-end output register.
// Payload bytes stream at one per cycle while res_stall is low; a reply holds the output until it is all sent.
// Reset clears the frame state, the tick count and the queue and loads the default registers.
// Depends on crcfr_pkg, crcfr_front, crcfr_queue and crcfr_back.
`default_nettype none
module crc32_frame_receiver_core #(
	parameter int unsigned MAX_PAYLOAD = 256
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  byte_valid,
	output logic                 byte_stall,
	input  crcfr_pkg::in_item_t  byte_item,
	output logic                 res_valid,
	input  wire                  res_stall,
	output crcfr_pkg::out_item_t res_item,
	input  wire                  cfg_wr_en,
	input  wire [1:0]            cfg_index,
	input  wire [15:0]           cfg_data
);

	crcfr_pkg::cfg_t cfg_q;
	logic            q_full;
	logic            push;
	crcfr_pkg::job_t push_job;
	logic            pop;
	logic            head_valid;
	crcfr_pkg::job_t head_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_marker  <= 8'd126;
			cfg_q.nack_code     <= 8'd2;
			cfg_q.timeout_code  <= 8'd3;
			cfg_q.timeout_ticks <= 16'd1000;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				crcfr_pkg::CFG_START_MARKER:  cfg_q.start_marker  <= cfg_data[7:0];
				crcfr_pkg::CFG_NACK_CODE:     cfg_q.nack_code     <= cfg_data[7:0];
				crcfr_pkg::CFG_TIMEOUT_CODE:  cfg_q.timeout_code  <= cfg_data[7:0];
				crcfr_pkg::CFG_TIMEOUT_TICKS: cfg_q.timeout_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

	assign byte_stall = q_full;

	crcfr_front #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(byte_valid),
		.item      (byte_item),
		.queue_full(q_full),
		.cfg       (cfg_q),
		.job_valid (push),
		.job       (push_job)
	);

	crcfr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.pop       (pop),
		.head_valid(head_valid),
		.head_job  (head_job),
		.full      (q_full)
	);

	crcfr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(head_valid),
		.job      (head_job),
		.job_pop  (pop),
		.cfg      (cfg_q),
		.res_valid(res_valid),
		.res_item (res_item),
		.res_stall(res_stall)
	);

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !push)
		else $error("job pushed into a full queue");

	a_reply_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.result_kind == crcfr_pkg::RK_REPLY |-> !res_item.last_of_run)
		else $error("reply byte marked as last result");

	a_status_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.result_kind == crcfr_pkg::RK_STATUS
			|-> res_item.last_of_run && res_item.data_byte == 8'h00)
		else $error("status result malformed");

	a_pop_needs_job: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("back end popped an empty queue");

endmodule
`default_nettype wire
